FILE: rtl/gpr_pkg.sv
package gpr_pkg;

	// Register file
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_SPEED  = 3'd0,
		REG_MAX_SPEED  = 3'd1,
		REG_KP_GAIN    = 3'd2,
		REG_KI_GAIN    = 3'd3,
		REG_INT_STEP   = 3'd4,
		REG_P_LIMIT    = 3'd5,
		REG_OUT_MIN    = 3'd6,
		REG_OUT_MAX    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] min_speed;
		logic [15:0] max_speed;
		logic [9:0]  kp_gain;
		logic [9:0]  ki_gain;
		logic [6:0]  integration_step;
		logic [14:0] p_limit;
		logic [14:0] out_min;
		logic [14:0] out_max;
	} cfg_t;

	// Microcode
	localparam int STEP_W = 4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_WAIT_IN,   // hold until an input beat, latch error and window flag
		OP_MUL,       // product register <= a * b
		OP_ABS,       // magnitude and sign of the product
		OP_FIX,       // finish divide by ten, write P or I term
		OP_INTEG,     // integral += low 16 bits of product
		OP_CLAMP,     // clamp P, I and integral
		OP_SUM,       // drive = clamp(P + I)
		OP_PUT        // hand result to output register
	} op_t;

	typedef enum logic [1:0] {
		A_ERR,
		A_INTEG,
		A_MAG
	} asel_t;

	typedef enum logic [1:0] {
		B_KP,
		B_KI,
		B_STEP,
		B_RECIP
	} bsel_t;

	typedef enum logic {
		DST_P,
		DST_I
	} dst_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_OUTSIDE,
		JMP_ALWAYS
	} jmp_t;

	typedef struct packed {
		op_t               op;
		asel_t             a_sel;
		bsel_t             b_sel;
		dst_t              dst;
		jmp_t              jmp;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic hold;     // current step waits on a handshake
		logic outside;  // latched item lies outside the speed window
	} status_t;

	localparam logic [STEP_W-1:0] STEP_WAIT = 4'd0;
	localparam logic [STEP_W-1:0] STEP_PUT  = 4'd13;

	// Control store
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c = '{op: OP_NOP, a_sel: A_ERR, b_sel: B_KP, dst: DST_P, jmp: JMP_NONE,
		      target: STEP_WAIT};
		unique case (step)
			4'd0: c.op = OP_WAIT_IN;
			4'd1: begin
				c.op = OP_MUL; c.a_sel = A_ERR; c.b_sel = B_KP;
				c.jmp = JMP_OUTSIDE; c.target = STEP_PUT;
			end
			4'd2: c.op = OP_ABS;
			4'd3: begin c.op = OP_MUL; c.a_sel = A_MAG; c.b_sel = B_RECIP; end
			4'd4: begin c.op = OP_FIX; c.dst = DST_P; end
			4'd5: begin c.op = OP_MUL; c.a_sel = A_ERR; c.b_sel = B_STEP; end
			4'd6: c.op = OP_INTEG;
			4'd7: begin c.op = OP_MUL; c.a_sel = A_INTEG; c.b_sel = B_KI; end
			4'd8: c.op = OP_ABS;
			4'd9: begin c.op = OP_MUL; c.a_sel = A_MAG; c.b_sel = B_RECIP; end
			4'd10: begin c.op = OP_FIX; c.dst = DST_I; end
			4'd11: c.op = OP_CLAMP;
			4'd12: c.op = OP_SUM;
			4'd13: begin c.op = OP_PUT; c.jmp = JMP_ALWAYS; c.target = STEP_WAIT; end
			default: begin c.op = OP_NOP; c.jmp = JMP_ALWAYS; c.target = STEP_WAIT; end
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/gpr_cfg.sv
module gpr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [gpr_pkg::CFG_IDX_W-1:0]  index,
	input  logic [gpr_pkg::CFG_DATA_W-1:0] data,
	output gpr_pkg::cfg_t                 cfg
);
	import gpr_pkg::*;

	cfg_t cfg_q;

	// Register writes, each truncated to its field width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_speed        <= 16'd0;
			cfg_q.max_speed        <= 16'd65535;
			cfg_q.kp_gain          <= 10'd10;
			cfg_q.ki_gain          <= 10'd10;
			cfg_q.integration_step <= 7'd0;
			cfg_q.p_limit          <= 15'd32767;
			cfg_q.out_min          <= 15'd0;
			cfg_q.out_max          <= 15'd32767;
		end else if (we) begin
			unique case (reg_idx_t'(index))
				REG_MIN_SPEED: cfg_q.min_speed        <= data;
				REG_MAX_SPEED: cfg_q.max_speed        <= data;
				REG_KP_GAIN:   cfg_q.kp_gain          <= data[9:0];
				REG_KI_GAIN:   cfg_q.ki_gain          <= data[9:0];
				REG_INT_STEP:  cfg_q.integration_step <= data[6:0];
				REG_P_LIMIT:   cfg_q.p_limit          <= data[14:0];
				REG_OUT_MIN:   cfg_q.out_min          <= data[14:0];
				REG_OUT_MAX:   cfg_q.out_max          <= data[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/gpr_seq.sv
module gpr_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  gpr_pkg::status_t  status,
	output gpr_pkg::ctrl_t    ctrl
);
	import gpr_pkg::*;

	logic [STEP_W-1:0] pc_q;
	logic [STEP_W-1:0] pc_next;
	logic              take;

	assign ctrl = ucode(pc_q);

	// Next step: hold, jump or fall through
	always_comb begin
		unique case (ctrl.jmp)
			JMP_OUTSIDE: take = status.outside;
			JMP_ALWAYS:  take = 1'b1;
			default:     take = 1'b0;
		endcase
		priority if (status.hold) pc_next = pc_q;
		else if (take)            pc_next = ctrl.target;
		else                      pc_next = pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

FILE: rtl/gpr_dp.sv
module gpr_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  gpr_pkg::cfg_t    cfg,
	input  gpr_pkg::ctrl_t   ctrl,
	output gpr_pkg::status_t status,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [15:0]      measured_speed,
	input  logic [15:0]      target_speed,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [14:0]      drive_value,
	output logic             regulated
);
	import gpr_pkg::*;

	// floor(2^28 / 10): quotient estimate is low by at most one
	localparam logic signed [25:0] RECIP_MUL = 26'sd26843545;
	localparam int                 RECIP_SH  = 28;
	localparam logic signed [15:0] INT_FLOOR = 16'sd110;
	localparam logic signed [15:0] INT_CEIL  = 16'sd950;

	logic signed [15:0] err_q;
	logic               outside_q;
	logic signed [51:0] prod_q;
	logic [24:0]        mag_q;
	logic               neg_q;
	logic signed [22:0] p_q;
	logic signed [22:0] i_q;
	logic signed [15:0] integ_q;
	logic [14:0]        drive_q;

	logic               out_valid_q;
	logic [14:0]        out_drive_q;
	logic               out_reg_q;

	logic               in_fire;
	logic               out_free;
	logic               in_window;
	logic signed [25:0] mul_a;
	logic signed [25:0] mul_b;
	logic signed [51:0] mul_p;
	logic signed [25:0] abs_in;
	logic [21:0]        qe;
	logic [25:0]        ten_qe;
	logic [25:0]        rem;
	logic signed [22:0] q;
	logic signed [22:0] quo;
	logic signed [22:0] lim;
	logic signed [22:0] lo23;
	logic signed [22:0] hi23;
	logic signed [22:0] p_cl;
	logic signed [22:0] i_cl;
	logic signed [15:0] integ_cl;
	logic signed [17:0] sum;
	logic signed [17:0] sum_cl;

	// Handshake and sequencer status
	assign in_ready  = (ctrl.op == OP_WAIT_IN);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign in_window = (measured_speed > cfg.min_speed) && (measured_speed < cfg.max_speed);

	always_comb begin
		unique case (ctrl.op)
			OP_WAIT_IN: status.hold = !in_valid;
			OP_PUT:     status.hold = !out_free;
			default:    status.hold = 1'b0;
		endcase
		status.outside = outside_q;
	end

	// Shared multiplier operands
	always_comb begin
		unique case (ctrl.a_sel)
			A_ERR:   mul_a = 26'(err_q);
			A_INTEG: mul_a = 26'(integ_q);
			default: mul_a = $signed({1'b0, mag_q});
		endcase
		unique case (ctrl.b_sel)
			B_KP:    mul_b = $signed({16'd0, cfg.kp_gain});
			B_KI:    mul_b = $signed({16'd0, cfg.ki_gain});
			B_STEP:  mul_b = $signed({19'd0, cfg.integration_step});
			default: mul_b = RECIP_MUL;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Divide by ten: estimate, remainder check, sign restore
	assign abs_in = prod_q[25] ? -prod_q[25:0] : prod_q[25:0];
	assign qe     = prod_q[RECIP_SH+21:RECIP_SH];
	assign ten_qe = 26'({qe, 3'b000}) + 26'({qe, 1'b0});
	assign rem    = 26'({1'b0, mag_q}) - ten_qe;
	assign q      = $signed({1'b0, qe}) + $signed(23'(rem >= 26'd10));
	assign quo    = neg_q ? -q : q;

	// Saturation
	assign lim  = $signed({8'd0, cfg.p_limit});
	assign lo23 = $signed({8'd0, cfg.out_min});
	assign hi23 = $signed({8'd0, cfg.out_max});

	always_comb begin
		p_cl = p_q;
		if (p_cl < -lim) p_cl = -lim;
		if (p_cl > lim)  p_cl = lim;
		i_cl = i_q;
		if (i_cl < lo23) i_cl = lo23;
		if (i_cl > hi23) i_cl = hi23;
		integ_cl = integ_q;
		if (integ_cl < INT_FLOOR) integ_cl = INT_FLOOR;
		if (integ_cl > INT_CEIL)  integ_cl = INT_CEIL;
		// clamped terms fit 17 signed bits; P may be negative
		sum    = 18'($signed(p_q[16:0])) + 18'($signed(i_q[16:0]));
		sum_cl = sum;
		if (sum_cl < 18'(lo23)) sum_cl = 18'(lo23);
		if (sum_cl > 18'(hi23)) sum_cl = 18'(hi23);
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			err_q     <= $signed(target_speed - measured_speed);
			outside_q <= !in_window;
		end
		if (ctrl.op == OP_MUL) prod_q <= mul_p;
		if (ctrl.op == OP_ABS) begin
			mag_q <= abs_in[24:0];
			neg_q <= prod_q[25];
		end
		if (ctrl.op == OP_FIX) begin
			if (ctrl.dst == DST_P) p_q <= quo;
			else                   i_q <= quo;
		end
		if (ctrl.op == OP_CLAMP) begin
			p_q <= p_cl;
			i_q <= i_cl;
		end
		if (ctrl.op == OP_PUT && out_free) begin
			out_drive_q <= drive_q;
			out_reg_q   <= !outside_q;
		end
	end

	// Regulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			drive_q <= '0;
		end else begin
			if (ctrl.op == OP_INTEG) integ_q <= integ_q + prod_q[15:0];
			if (ctrl.op == OP_CLAMP) integ_q <= integ_cl;
			if (ctrl.op == OP_SUM)   drive_q <= sum_cl[14:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_PUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_value = out_drive_q;
	assign regulated   = out_reg_q;

endmodule

FILE: rtl/gated_pi_regulator_unit.sv
// Channel   | Signals                      | Beat contents
// ----------+------------------------------+--------------------------------------
// input     | s_axis_tvalid/tready/tdata   | measured_speed, target_speed
// result    | m_axis_tvalid/tready/tdata/  | drive_value (tdata), regulated (tuser)
//           | tuser                        |
// config    | cfg_we, cfg_index, cfg_data  | register write, no read-back
//
// An item inside the speed window runs every step from the accepting edge to the
// hand-off; one outside it jumps from the first multiply to the hand-off step. Items
// are taken only at the wait step. The microprogram runs its steps one per cycle,
// save where it holds at the wait or hand-off step, around a single shared 26x26
// multiplier that serves both gains, the integration step and the divide by ten.
// Reset clears the step counter, the integral, the held drive and the output
// valid. A full output register stalls the program at its last step; the next
// input beat is taken while a result waits to be taken.
module gated_pi_regulator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [31:0]                    s_axis_tdata,   // [15:0] measured_speed, [31:16] target_speed
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [15:0]                    m_axis_tdata,   // [14:0] drive_value, [15] zero
	output logic [0:0]                     m_axis_tuser,   // [0] regulated
	input  logic                           cfg_we,
	input  logic [gpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gpr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gpr_pkg::*;

	cfg_t    cfg;
	ctrl_t   ctrl;
	status_t status;
	logic [14:0] drive_value;
	logic        regulated;

	gpr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	gpr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	gpr_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.ctrl           (ctrl),
		.status         (status),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.measured_speed (s_axis_tdata[15:0]),
		.target_speed   (s_axis_tdata[31:16]),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.drive_value    (drive_value),
		.regulated      (regulated)
	);

	assign m_axis_tdata = {1'b0, drive_value};
	assign m_axis_tuser = regulated;

`ifndef SYNTHESIS
	// An accepted beat moves the program off its wait step
	a_leave_wait: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("sequencer stayed on wait step after input beat");

	// A completed hand-off step always shows a result next cycle
	a_put_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_PUT) && !status.hold |=> m_axis_tvalid)
		else $error("result not presented after hand-off step");

	// A result appears only from the hand-off step
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(ctrl.op == OP_PUT))
		else $error("output valid rose outside hand-off step");

	// Input and output handshakes are apart from the program's point of view
	a_no_wait_put: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (ctrl.op != OP_PUT))
		else $error("input ready during hand-off step");
`endif

endmodule

FILE: tb/sv/gated_pi_regulator_unit_test.sv
`timescale 1ns / 100ps

module gated_pi_regulator_unit_test;
	import gpr_pkg::*;

	localparam int N_ROWS          = 43;
	localparam int N_PHASES        = 12;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int MAX_PAUSE       = 18;
	localparam int SETTLE_CYCLES   = 20;   // a bit over the regulated path
	localparam int MAX_REPORTS     = 50;
	localparam int GAIN_DIV        = 10;
	localparam int INTEG_FLOOR     = 110;
	localparam int INTEG_CEIL      = 950;
	localparam longint TIMEOUT_NS  = 6_000_000;

	typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

	// one line of the directed script; for writes, a holds the register value
	typedef struct {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [15:0] a;
		logic [15:0] b;
		bit          typed;
		logic [14:0] drive;
		bit          regulated;
	} row_t;

	typedef struct {
		logic [14:0] drive;
		logic        regulated;
	} drive_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [15:0] measured_speed, [31:16] target_speed
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // [14:0] drive_value, [15] zero
	logic [0:0]  m_axis_tuser;        // [0] regulated
	logic        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_MIN_SPEED;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// regulator state as we expect it
	cfg_t settings = '{min_speed: 16'd0, max_speed: 16'hFFFF, kp_gain: 10'd10,
	                   ki_gain: 10'd10, integration_step: 7'd0, p_limit: 15'h7FFF,
	                   out_min: 15'd0, out_max: 15'h7FFF};
	int          integ = 0;
	logic [15:0] held_drive = '0;

	drive_beat_t pending_drive[$];
	bit src_idle = 1'b1;
	bit dst_idle = 1'b1;
	int fail_count = 0;
	int beats_seen = 0;
	int beats_regulated = 0;

	row_t script [N_ROWS] = '{
		// window edges at reset, then zero error inside
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd0,     16'd500,   1'b1, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd65535, 16'd500,   1'b1, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd1000,  16'd1000,  1'b1, 15'd0,   1'b1},
		// error wrap and both error extremes
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd1,     16'd65535, 1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd100,   16'd32867, 1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd32868, 16'd100,   1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd65534, 16'd0,     1'b0, 15'd0,   1'b0},
		// large gains: terms overflow 16 bits before saturation
		'{ROW_WRITE, REG_KP_GAIN,   16'd1000,  16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_WRITE, REG_KI_GAIN,   16'd1000,  16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_WRITE, REG_INT_STEP,  16'd100,   16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd1,     16'd32768, 1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd40000, 16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd20000, 16'd20000, 1'b0, 15'd0,   1'b0},
		'{ROW_WRITE, REG_P_LIMIT,   16'd0,     16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd300,   16'd5000,  1'b0, 15'd0,   1'b0},
		// data wider than the register is cut to its width
		'{ROW_WRITE, REG_KP_GAIN,   16'hFFFF,  16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_WRITE, REG_KI_GAIN,   16'd1023,  16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_WRITE, REG_INT_STEP,  16'hFFFF,  16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_WRITE, REG_P_LIMIT,   16'd32767, 16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd500,   16'd700,   1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd700,   16'd500,   1'b0, 15'd0,   1'b0},
		// inverted output bounds always give out_max
		'{ROW_WRITE, REG_OUT_MIN,   16'd500,   16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_WRITE, REG_OUT_MAX,   16'd200,   16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd1234,  16'd4321,  1'b1, 15'd200, 1'b1},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd60000, 16'd10,    1'b1, 15'd200, 1'b1},
		// window bounds are exclusive
		'{ROW_WRITE, REG_MIN_SPEED, 16'd1000,  16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_WRITE, REG_MAX_SPEED, 16'd1001,  16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd1000,  16'd0,     1'b1, 15'd200, 1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd1001,  16'd0,     1'b1, 15'd200, 1'b0},
		'{ROW_WRITE, REG_MIN_SPEED, 16'd999,   16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd1000,  16'd3000,  1'b1, 15'd200, 1'b1},
		'{ROW_WRITE, REG_OUT_MAX,   16'd0,     16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_WRITE, REG_OUT_MIN,   16'd0,     16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd1000,  16'd65535, 1'b1, 15'd0,   1'b1},
		// crossed window lets nothing through
		'{ROW_WRITE, REG_MIN_SPEED, 16'd65535, 16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_WRITE, REG_MAX_SPEED, 16'd0,     16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd30000, 16'd1,     1'b1, 15'd0,   1'b0},
		// zero gains
		'{ROW_WRITE, REG_MIN_SPEED, 16'd0,     16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_WRITE, REG_MAX_SPEED, 16'd65535, 16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_WRITE, REG_OUT_MAX,   16'hFFFF,  16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_WRITE, REG_KP_GAIN,   16'd0,     16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_WRITE, REG_KI_GAIN,   16'd0,     16'd0,     1'b0, 15'd0,   1'b0},
		'{ROW_ITEM,  REG_MIN_SPEED, 16'd2,     16'd65000, 1'b1, 15'd0,   1'b1}
	};

	gated_pi_regulator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int bound(input int v, input int lo, input int hi);
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return v;
	endfunction

	function automatic int pause_len(input bit on);
		return on ? $urandom_range(0, MAX_PAUSE) : 0;
	endfunction

	// one control tick: PI update inside the window, hold outside
	function automatic void regulate(input logic [15:0] spd, input logic [15:0] tgt,
	                                 output logic [14:0] drv, output logic reg_flag);
		logic signed [15:0] err;
		logic signed [15:0] wrapped;
		int p_term, i_term, acc, lo, hi, lim;
		reg_flag = (spd > settings.min_speed) && (spd < settings.max_speed);
		if (reg_flag) begin
			lo  = int'(settings.out_min);
			hi  = int'(settings.out_max);
			lim = int'(settings.p_limit);
			err = tgt - spd;
			p_term = (int'(settings.kp_gain) * int'(err)) / GAIN_DIV;
			acc = integ + int'(err) * int'(settings.integration_step);
			wrapped = acc[15:0];
			integ = int'(wrapped);
			i_term = (int'(settings.ki_gain) * integ) / GAIN_DIV;
			integ = bound(integ, INTEG_FLOOR, INTEG_CEIL);
			p_term = bound(p_term, -lim, lim);
			i_term = bound(i_term, lo, hi);
			acc = bound(p_term + i_term, lo, hi);
			held_drive = acc[15:0];
		end
		drv = held_drive[14:0];
	endfunction

	task automatic program_reg(input reg_idx_t idx, input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		case (idx)
			REG_MIN_SPEED: settings.min_speed        = v;
			REG_MAX_SPEED: settings.max_speed        = v;
			REG_KP_GAIN:   settings.kp_gain          = v[9:0];
			REG_KI_GAIN:   settings.ki_gain          = v[9:0];
			REG_INT_STEP:  settings.integration_step = v[6:0];
			REG_P_LIMIT:   settings.p_limit          = v[14:0];
			REG_OUT_MIN:   settings.out_min          = v[14:0];
			REG_OUT_MAX:   settings.out_max          = v[14:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// send one beat; the expectation is queued at the accepting edge
	task automatic push_sample(input logic [15:0] spd, input logic [15:0] tgt,
	                           input bit typed, input logic [14:0] tdrive, input bit treg);
		int gap;
		drive_beat_t want;
		gap = pause_len(src_idle);
		cfg_we <= 1'b0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {tgt, spd};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		regulate(spd, tgt, want.drive, want.regulated);
		if (typed) begin
			want.drive     = tdrive;
			want.regulated = treg;
		end
		pending_drive.push_back(want);
	endtask

	// stop sending and let every queued result come back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_drive.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register set for one random phase; the first three are fixed extremes
	task automatic load_phase(input int k);
		logic [15:0] v_min, v_max, v_kp, v_ki, v_step, v_plim, v_omin, v_omax;
		case (k)
			0: begin
				v_min = 16'd0; v_max = 16'hFFFF; v_kp = 16'd10; v_ki = 16'd10;
				v_step = 16'd0; v_plim = 16'h7FFF; v_omin = 16'd0; v_omax = 16'h7FFF;
			end
			1: begin
				v_min = 16'd0; v_max = 16'hFFFF; v_kp = 16'h3FF; v_ki = 16'h3FF;
				v_step = 16'h7F; v_plim = 16'h7FFF; v_omin = 16'd0; v_omax = 16'h7FFF;
			end
			2: begin
				v_min = 16'd0; v_max = 16'hFFFF; v_kp = 16'd0; v_ki = 16'd1000;
				v_step = 16'd1; v_plim = 16'd0; v_omin = 16'h7FFF; v_omax = 16'h7FFF;
			end
			default: begin
				v_min  = (k % 4 == 3) ? 16'($urandom_range(0, 65535))
				                      : 16'($urandom_range(0, 3000));
				v_max  = (k % 4 == 3) ? 16'($urandom_range(0, 65535))
				                      : 16'($urandom_range(30000, 65535));
				v_kp   = 16'($urandom_range(0, 1023));
				v_ki   = 16'($urandom_range(0, 1023));
				v_step = (k % 2 == 1) ? 16'($urandom_range(0, 4))
				                      : 16'($urandom_range(0, 127));
				v_plim = 16'($urandom_range(0, 32767));
				v_omin = 16'($urandom_range(0, 4000));
				v_omax = 16'($urandom_range(2000, 32767));
			end
		endcase
		program_reg(REG_MIN_SPEED, v_min);
		program_reg(REG_MAX_SPEED, v_max);
		program_reg(REG_KP_GAIN, v_kp);
		program_reg(REG_KI_GAIN, v_ki);
		program_reg(REG_INT_STEP, v_step);
		program_reg(REG_P_LIMIT, v_plim);
		program_reg(REG_OUT_MIN, v_omin);
		program_reg(REG_OUT_MAX, v_omax);
	endtask

	// stimulus: reset, directed script, random phases, drain, verdict
	initial begin
		bit busy;
		logic [15:0] spd, tgt;
		int lo, hi;
		busy = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < N_ROWS; n++) begin
			if (script[n].kind == ROW_WRITE) begin
				if (busy) begin
					settle();
					busy = 1'b0;
				end
				program_reg(script[n].idx, script[n].a);
			end else begin
				push_sample(script[n].a, script[n].b, script[n].typed,
				            script[n].drive, script[n].regulated);
				busy = 1'b1;
			end
		end

		for (int k = 0; k < N_PHASES; k++) begin
			settle();
			load_phase(k);
			src_idle = (k % 3 != 0);
			dst_idle = (k % 3 != 1);
			lo = int'(settings.min_speed);
			hi = int'(settings.max_speed);
			for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
				// mostly in-window speeds, target near the speed or anywhere
				if (hi - lo >= 2 && $urandom_range(0, 9) < 8)
					spd = 16'($urandom_range(lo + 1, hi - 1));
				else
					spd = 16'($urandom());
				if ($urandom_range(0, 1) == 1)
					tgt = spd + 16'($urandom_range(0, 400)) - 16'd200;
				else
					tgt = 16'($urandom());
				push_sample(spd, tgt, 1'b0, '0, 1'b0);
			end
		end
		settle();

		$display("Checked %0d result beats (%0d regulated, %0d held) from %0d directed rows",
		         beats_seen, beats_regulated, beats_seen - beats_regulated, N_ROWS);
		$display("and %0d register phases with random speeds, set points and stalls.",
		         N_PHASES);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// result side: random stalls, compare each beat with the oldest expectation
	initial begin
		int gap;
		drive_beat_t want;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = pause_len(dst_idle);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			beats_seen++;
			if (m_axis_tuser[0]) beats_regulated++;
			if (pending_drive.size() == 0) begin
				fail_count++;
				$display("%0t: result beat with nothing expected, drive_value %0d regulated %0d",
				         $time, m_axis_tdata[14:0], m_axis_tuser[0]);
			end else begin
				want = pending_drive.pop_front();
				if (m_axis_tdata[14:0] !== want.drive) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: drive_value expected %0d got %0d",
						         $time, want.drive, m_axis_tdata[14:0]);
				end
				if (m_axis_tuser[0] !== want.regulated) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: regulated expected %0d got %0d",
						         $time, want.regulated, m_axis_tuser[0]);
				end
			end
		end
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timeout, %0d results still outstanding", $time, pending_drive.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/gpr_pkg.sv
rtl/gpr_cfg.sv
rtl/gpr_seq.sv
rtl/gpr_dp.sv
rtl/gated_pi_regulator_unit.sv
tb/sv/gated_pi_regulator_unit_test.sv
